// ----- rtl/tsrb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tsrb_pkg;

	// buffer geometry
	localparam int CAPACITY = 4096;
	localparam int READ_MAX = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = IDX_W + 1;

	// field widths
	localparam int TS_W   = 48;
	localparam int SMP_W  = 16;
	localparam int WORD_W = 2 * SMP_W;
	localparam int RCNT_W = 7;
	localparam int ST_W   = 3;
	localparam int REQ_W  = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

	// status codes
	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_PAST      = 3'd1;
	localparam logic [ST_W-1:0] ST_NODATA    = 3'd2;
	localparam logic [ST_W-1:0] ST_OVERWROTE = 3'd3;
	localparam logic [ST_W-1:0] ST_GAPFILL   = 3'd4;
	localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd5;

	localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CAPACITY);
	localparam logic [RCNT_W-1:0] RMAX_CNT = RCNT_W'(READ_MAX);

endpackage

`default_nettype wire

// ----- rtl/timestamped_sample_ring_buffer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Timestamped I/Q sample ring buffer: 4096 samples kept in one synchronous RAM, addressed
// by sample time relative to the oldest held sample. Requests are handled one at a time
// and in_ready is high only while the block is idle, though the last result of a request
// may still be waiting in the output register. A query goes from evaluation to the result
// state, as does a write in the past. Any other write goes from evaluation through a
// zero-fill of each gap slot (up to 4096), one slot a cycle through the single RAM write
// port, and the RAM write to the result state. A read run reads each sample from the RAM
// and then loads it into the output register; a stall on out_ready holds either output.

module timestamped_sample_ring_buffer_top (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire        [tsrb_pkg::REQ_W-1:0]       req_type,
	input  wire        [tsrb_pkg::TS_W-1:0]        timestamp,
	input  wire signed [tsrb_pkg::SMP_W-1:0]       in_i,
	input  wire signed [tsrb_pkg::SMP_W-1:0]       in_q,
	input  wire        [tsrb_pkg::RCNT_W-1:0]      read_count,
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic       [tsrb_pkg::ST_W-1:0]        status,
	output logic signed [tsrb_pkg::SMP_W-1:0]      out_i,
	output logic signed [tsrb_pkg::SMP_W-1:0]      out_q,
	output logic       [tsrb_pkg::CNT_W-1:0]       avail_count,
	output logic       [tsrb_pkg::CNT_W-1:0]       free_space,
	output logic                                   last
);
	import tsrb_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EVAL   = 3'd1;
	localparam logic [2:0] S_FILL   = 3'd2;
	localparam logic [2:0] S_WRITE  = 3'd3;
	localparam logic [2:0] S_RDUPD  = 3'd4;
	localparam logic [2:0] S_RDADDR = 3'd5;
	localparam logic [2:0] S_RDDATA = 3'd6;
	localparam logic [2:0] S_RESULT = 3'd7;

	logic [2:0]        state_q;
	logic [TS_W-1:0]   oldest_q;
	logic [CNT_W-1:0]  fill_q;
	logic [IDX_W-1:0]  head_q;

	// request held for the duration of the transaction
	logic [REQ_W-1:0]  req_q;
	logic [TS_W-1:0]   ts_q;
	logic [WORD_W-1:0] word_q;
	logic [RCNT_W-1:0] cnt_q;

	// evaluation results
	logic [TS_W-1:0]   base_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  avail_q;
	logic [CNT_W-1:0]  span_q;
	logic              ovf_q;
	logic [ST_W-1:0]   wr_st_q;
	logic [RCNT_W-1:0] len_q;
	logic [CNT_W-1:0]  fcnt_q;
	logic [IDX_W-1:0]  faddr_q;
	logic [ST_W-1:0]   res_st_q;
	logic [CNT_W-1:0]  res_av_q;

	// output register
	logic              out_valid_q;
	logic [ST_W-1:0]   status_q;
	logic [WORD_W-1:0] out_word_q;
	logic [CNT_W-1:0]  avail_count_q;
	logic [CNT_W-1:0]  free_space_q;
	logic              last_q;

	// sample memory
	logic [WORD_W-1:0] mem [CAPACITY];
	logic [WORD_W-1:0] rdata_q;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	logic [WORD_W-1:0] mem_wd;
	logic              mem_re;

	logic              accept;
	logic              out_free;
	logic              ld_rd;
	logic              ld_res;

	// evaluation datapath
	logic [TS_W-1:0]   base;
	logic [TS_W:0]     tm1;
	logic [TS_W:0]     ts_x;
	logic [TS_W:0]     gap;
	logic [TS_W-1:0]   diff;
	logic              is_past;
	logic              lt_end;
	logic              gt_end;
	logic              ovf;
	logic [IDX_W-1:0]  slot;
	logic [CNT_W-1:0]  gap_n;
	logic [CNT_W-1:0]  span;
	logic [CNT_W-1:0]  avail_rd;
	logic [CNT_W-1:0]  avail_wr;
	logic [RCNT_W-1:0] cnt_c;
	logic [RCNT_W-1:0] len;
	logic [ST_W-1:0]   wr_st;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign ld_rd    = (state_q == S_RDDATA) && out_free;
	assign ld_res   = (state_q == S_RESULT) && out_free;

	// span bounds and slot of the requested time
	always_comb begin
		base     = ((req_q == REQ_WRITE) && (fill_q == '0)) ? ts_q : oldest_q;
		tm1      = {1'b0, base} + {{(TS_W + 1 - CNT_W){1'b0}}, fill_q};
		ts_x     = {1'b0, ts_q};
		is_past  = ts_q < base;
		lt_end   = ts_x < tm1;
		gt_end   = ts_x > tm1;
		diff     = ts_q - base;
		gap      = ts_x - tm1;
		slot     = head_q + diff[IDX_W-1:0];
		gap_n    = (|gap[TS_W:IDX_W]) ? CAP_CNT : gap[CNT_W-1:0];
		ovf      = !lt_end && (|diff[TS_W-1:IDX_W]);
		span     = lt_end ? fill_q : diff[CNT_W-1:0] + CNT_W'(1);
		avail_rd = tm1[CNT_W-1:0] - ts_q[CNT_W-1:0];
		avail_wr = lt_end ? avail_rd : CNT_W'(1);
		cnt_c    = (cnt_q > RMAX_CNT) ? RMAX_CNT : cnt_q;
		len      = ({{(CNT_W - RCNT_W){1'b0}}, cnt_c} < avail_rd) ? cnt_c
			: avail_rd[RCNT_W-1:0];
		priority if (ovf) begin
			wr_st = ST_OVERFLOW;
		end else if (gt_end) begin
			wr_st = ST_GAPFILL;
		end else if (lt_end) begin
			wr_st = ST_OVERWROTE;
		end else begin
			wr_st = ST_OK;
		end
	end

	// control state and buffer bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			oldest_q <= '0;
			fill_q   <= '0;
			head_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					unique case (req_q)
						REQ_WRITE: begin
							priority if (is_past) begin
								state_q <= S_RESULT;
							end else if (gt_end) begin
								state_q <= S_FILL;
							end else begin
								state_q <= S_WRITE;
							end
						end
						REQ_READ: begin
							priority if (cnt_q == '0 || is_past || !lt_end) begin
								state_q <= S_RESULT;
							end else begin
								state_q <= S_RDUPD;
							end
						end
						default: begin
							state_q <= S_RESULT;
						end
					endcase
				end
				S_FILL: begin
					if (fcnt_q == CNT_W'(1)) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (ovf_q) begin
						oldest_q <= ts_q - TS_W'(CAPACITY - 1);
						head_q   <= idx_q + IDX_W'(1);
						fill_q   <= CAP_CNT;
					end else begin
						oldest_q <= base_q;
						fill_q   <= span_q;
					end
					state_q <= S_RESULT;
				end
				S_RDUPD: begin
					head_q   <= idx_q + {{(IDX_W - RCNT_W){1'b0}}, len_q};
					oldest_q <= ts_q + {{(TS_W - RCNT_W){1'b0}}, len_q};
					fill_q   <= avail_q - {{(CNT_W - RCNT_W){1'b0}}, len_q};
					state_q  <= S_RDADDR;
				end
				S_RDADDR: begin
					state_q <= S_RDDATA;
				end
				S_RDDATA: begin
					if (out_free) begin
						state_q <= (len_q == RCNT_W'(1)) ? S_IDLE : S_RDADDR;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture and per-transaction working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q  <= req_type;
					ts_q   <= timestamp;
					word_q <= {in_q, in_i};
					cnt_q  <= read_count;
				end
			end
			S_EVAL: begin
				base_q   <= base;
				idx_q    <= slot;
				span_q   <= span;
				ovf_q    <= ovf;
				wr_st_q  <= wr_st;
				len_q    <= len;
				fcnt_q   <= gap_n;
				faddr_q  <= head_q + fill_q[IDX_W-1:0];
				avail_q  <= (req_q == REQ_WRITE) ? avail_wr : avail_rd;
				res_av_q <= '0;
				unique case (req_q)
					REQ_WRITE: begin
						res_st_q <= ST_PAST;
					end
					REQ_READ: begin
						priority if (cnt_q == '0) begin
							res_st_q <= ST_NODATA;
						end else if (is_past) begin
							res_st_q <= ST_PAST;
						end else begin
							res_st_q <= ST_NODATA;
						end
					end
					REQ_QUERY: begin
						priority if (is_past) begin
							res_st_q <= ST_PAST;
						end else if (!lt_end) begin
							res_st_q <= ST_NODATA;
						end else begin
							res_st_q <= ST_OK;
							res_av_q <= avail_rd;
						end
					end
					default: begin
						res_st_q <= ST_NODATA;
					end
				endcase
			end
			S_FILL: begin
				faddr_q <= faddr_q + IDX_W'(1);
				fcnt_q  <= fcnt_q - CNT_W'(1);
			end
			S_WRITE: begin
				res_st_q <= wr_st_q;
				res_av_q <= avail_q;
			end
			S_RDADDR: begin
				idx_q <= idx_q + IDX_W'(1);
			end
			S_RDDATA: begin
				if (out_free) begin
					len_q <= len_q - RCNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// memory port control
	always_comb begin
		mem_we = (state_q == S_FILL) || (state_q == S_WRITE);
		mem_wa = (state_q == S_FILL) ? faddr_q : idx_q;
		mem_wd = (state_q == S_FILL) ? '0 : word_q;
		mem_re = (state_q == S_RDADDR);
	end

	// sample memory write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	// sample memory read port
	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= mem[idx_q];
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_rd || ld_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (ld_rd) begin
			status_q      <= ST_OK;
			out_word_q    <= rdata_q;
			avail_count_q <= avail_q;
			free_space_q  <= CAP_CNT - fill_q;
			last_q        <= (len_q == RCNT_W'(1));
		end else if (ld_res) begin
			status_q      <= res_st_q;
			out_word_q    <= '0;
			avail_count_q <= res_av_q;
			free_space_q  <= CAP_CNT - fill_q;
			last_q        <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_i       = out_word_q[SMP_W-1:0];
	assign out_q       = out_word_q[WORD_W-1:SMP_W];
	assign avail_count = avail_count_q;
	assign free_space  = free_space_q;
	assign last        = last_q;

endmodule

`default_nettype wire

// ----- rtl/tsrb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tsrb_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                in_valid,
	input wire                                in_ready,
	input wire                                out_valid,
	input wire                                out_ready,
	input wire        [tsrb_pkg::ST_W-1:0]    status,
	input wire signed [tsrb_pkg::SMP_W-1:0]   out_i,
	input wire signed [tsrb_pkg::SMP_W-1:0]   out_q,
	input wire        [tsrb_pkg::CNT_W-1:0]   avail_count,
	input wire        [tsrb_pkg::CNT_W-1:0]   free_space,
	input wire                                last
);
	import tsrb_pkg::*;

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_i)
			&& $stable(out_q) && $stable(avail_count) && $stable(last))
		else $error("result changed while stalled");

	// the block is busy in the cycle after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken on consecutive cycles");

	// results other than read samples carry no sample and close the transaction
	a_nonread: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> out_i == '0 && out_q == '0 && last)
		else $error("non-sample result malformed");

	// refused requests report nothing available
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_PAST || status == ST_NODATA) |-> avail_count == '0)
		else $error("refused request reports data");

	// an overflowing write leaves the buffer full with itself as newest sample
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OVERFLOW |-> free_space == '0
			&& avail_count == CNT_W'(1))
		else $error("overflow result inconsistent");

endmodule

bind timestamped_sample_ring_buffer_top tsrb_checker u_tsrb_checker (.*);

`default_nettype wire
